>>> rtl/core/lst_pkg.sv
`timescale 1ns / 1ps

package lst_pkg;

    // Largest number of metrics that the window mask can address.
    localparam int MAX_METRICS          = 32;
    localparam int METRIC_SLOTS_DEFAULT = 32;

    localparam int CYCLES_W = 32;
    localparam int COUNT_W  = 32;
    localparam int SUM_W    = 64;
    localparam int GEN_W    = 16;
    localparam int METRIC_W = 6;
    localparam int MASK_W   = 32;

    // Command codes.
    typedef enum logic [2:0] {
        CMD_BEGIN_SPAN   = 3'd0,
        CMD_END_SPAN     = 3'd1,
        CMD_RECORD_CALL  = 3'd2,
        CMD_RECORD_ONLY  = 3'd3,
        CMD_START_WINDOW = 3'd4,
        CMD_FREEZE       = 3'd5,
        CMD_READ         = 3'd6,
        CMD_SET_BUDGET   = 3'd7
    } cmd_t;

    // One statistics entry of the table.
    typedef struct packed {
        logic [COUNT_W-1:0]  calls;
        logic [COUNT_W-1:0]  samples;
        logic [CYCLES_W-1:0] minimum;
        logic [CYCLES_W-1:0] maximum;
        logic [CYCLES_W-1:0] latest;
        logic [SUM_W-1:0]    total;
        logic [COUNT_W-1:0]  overruns;
        logic [CYCLES_W-1:0] budget;
    } entry_t;

    // Operations applied to an entry by one command.
    typedef struct packed {
        logic bump_calls;
        logic record;
    } entry_op_t;

    // Value of an entry that has never been written: cleared statistics, open budget.
    localparam entry_t ENTRY_RESET = '{
        calls:    '0,
        samples:  '0,
        minimum:  '0,
        maximum:  '0,
        latest:   '0,
        total:    '0,
        overruns: '0,
        budget:   '1
    };

    localparam logic [GEN_W-1:0] GEN_RESET = GEN_W'(1);

    // The generation counts up, wraps, and never takes the value zero.
    function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] gen);
        logic [GEN_W-1:0] result;
        if (gen == '1) begin
            result = GEN_W'(1);
        end else begin
            result = gen + GEN_W'(1);
        end
        return result;
    endfunction

endpackage

>>> rtl/core/lst_entry_update.sv
`timescale 1ns / 1ps

// Computes the new statistics of one entry: optional call count bump and sample record.
module lst_entry_update (
    input  lst_pkg::entry_t                  entry_in,
    input  lst_pkg::entry_op_t               op,
    input  logic [lst_pkg::CYCLES_W-1:0]     cycles,
    output lst_pkg::entry_t                  entry_out
);

    logic [lst_pkg::COUNT_W-1:0] samples_inc;

    assign samples_inc = (entry_in.samples == '1) ? entry_in.samples
                                                  : entry_in.samples + lst_pkg::COUNT_W'(1);

    always_comb begin
        entry_out = entry_in;

        // Saturating call count.
        if (op.bump_calls && (entry_in.calls != '1)) begin
            entry_out.calls = entry_in.calls + lst_pkg::COUNT_W'(1);
        end

        // Sample record: counts, extremes, latest value, running total and overruns.
        if (op.record) begin
            entry_out.samples = samples_inc;
            if ((samples_inc == lst_pkg::COUNT_W'(1)) || (cycles < entry_in.minimum)) begin
                entry_out.minimum = cycles;
            end
            if (cycles > entry_in.maximum) begin
                entry_out.maximum = cycles;
            end
            entry_out.latest = cycles;
            entry_out.total  = entry_in.total + lst_pkg::SUM_W'(cycles);
            if ((cycles > entry_in.budget) && (entry_in.overruns != '1)) begin
                entry_out.overruns = entry_in.overruns + lst_pkg::COUNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/core/latency_statistics_table.sv
`timescale 1ns / 1ps

// Latency statistics table. Each command item is taken into an input register, and when the
// output register is free the addressed entry is read, updated and written back while the
// result item is loaded into the output register. One item can be accepted in every cycle as
// long as results are taken. The entries live in flip-flops with one valid bit each; reset
// clears the valid bits at once, an entry that was never written reads as cleared statistics
// with an all-ones budget, and there is no clearing pass. The throughput limit is the
// read-modify-write of an entry, which completes as the item leaves the input register.
module latency_statistics_table #(
    parameter int METRIC_SLOTS = lst_pkg::METRIC_SLOTS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_cmd,
    input  logic [lst_pkg::METRIC_W-1:0]       s_metric,
    input  logic [lst_pkg::CYCLES_W-1:0]       s_cycles,
    input  logic [lst_pkg::MASK_W-1:0]         s_window_mask,
    input  logic [lst_pkg::GEN_W-1:0]          s_span_generation,
    input  logic                               s_span_active,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_ok,
    output logic [lst_pkg::COUNT_W-1:0]        m_calls,
    output logic [lst_pkg::COUNT_W-1:0]        m_samples,
    output logic [lst_pkg::CYCLES_W-1:0]       m_minimum,
    output logic [lst_pkg::CYCLES_W-1:0]       m_maximum,
    output logic [lst_pkg::CYCLES_W-1:0]       m_latest,
    output logic [lst_pkg::SUM_W-1:0]          m_total_cycles,
    output logic [lst_pkg::COUNT_W-1:0]        m_overruns,
    output logic [lst_pkg::CYCLES_W-1:0]       m_budget,
    output logic                               m_meets_budget,
    output logic [lst_pkg::GEN_W-1:0]          m_generation,
    output logic                               m_sampling_on
);

    localparam int IDX_W = (METRIC_SLOTS > 1) ? $clog2(METRIC_SLOTS) : 1;
    localparam logic [lst_pkg::MASK_W-1:0] VALID_BITS =
        lst_pkg::MASK_W'((64'd1 << METRIC_SLOTS) - 64'd1);

    // Input register.
    logic                               in_valid_reg;
    lst_pkg::cmd_t                      in_cmd_reg;
    logic [lst_pkg::METRIC_W-1:0]       in_metric_reg;
    logic [lst_pkg::CYCLES_W-1:0]       in_cycles_reg;
    logic [lst_pkg::MASK_W-1:0]         in_mask_reg;
    logic [lst_pkg::GEN_W-1:0]          in_span_gen_reg;
    logic                               in_span_active_reg;

    // Global control state.
    logic [lst_pkg::MASK_W-1:0]         pending_reg, pending_next;
    logic                               window_reg, window_next;
    logic                               enable_reg, enable_next;
    logic [lst_pkg::GEN_W-1:0]          gen_reg, gen_next;

    // Entry storage.
    lst_pkg::entry_t                    entry_reg [METRIC_SLOTS];
    logic [METRIC_SLOTS-1:0]            entry_valid_reg;

    // Output register.
    logic                               out_valid_reg;
    logic                               out_ok_reg;
    lst_pkg::entry_t                    out_entry_reg;
    logic [lst_pkg::GEN_W-1:0]          out_gen_reg;
    logic                               out_enable_reg;

    logic                               fire;
    logic                               metric_ok;
    logic [IDX_W-1:0]                   idx;
    logic                               pend_bit;
    logic [lst_pkg::MASK_W-1:0]         pend_cleared;
    lst_pkg::entry_t                    entry_cur;
    lst_pkg::entry_t                    entry_upd;
    lst_pkg::entry_t                    entry_next;
    lst_pkg::entry_op_t                 op;
    logic                               complete;
    logic                               budget_we;
    logic                               entry_we;
    logic                               ok;

    // Handshake: the item in the input register moves on when the output register is free.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg         <= lst_pkg::cmd_t'(s_cmd);
            in_metric_reg      <= s_metric;
            in_cycles_reg      <= s_cycles;
            in_mask_reg        <= s_window_mask;
            in_span_gen_reg    <= s_span_generation;
            in_span_active_reg <= s_span_active;
        end
    end

    // Entry read: unwritten entries read as the reset value.
    assign metric_ok    = in_metric_reg < lst_pkg::METRIC_W'(METRIC_SLOTS);
    assign idx          = in_metric_reg[IDX_W-1:0];
    assign entry_cur    = entry_valid_reg[idx] ? entry_reg[idx] : lst_pkg::ENTRY_RESET;
    assign pend_bit     = pending_reg[in_metric_reg[4:0]];
    assign pend_cleared = pending_reg & ~(lst_pkg::MASK_W'(1) << in_metric_reg[4:0]);

    lst_entry_update u_entry_update (
        .entry_in  (entry_cur),
        .op        (op),
        .cycles    (in_cycles_reg),
        .entry_out (entry_upd)
    );

    // Command decode and control state update.
    always_comb begin
        ok            = 1'b0;
        op.bump_calls = 1'b0;
        op.record     = 1'b0;
        complete      = 1'b0;
        budget_we     = 1'b0;
        gen_next      = gen_reg;
        enable_next   = enable_reg;
        window_next   = window_reg;
        pending_next  = pending_reg;

        case (in_cmd_reg)
            lst_pkg::CMD_BEGIN_SPAN: begin
                ok = enable_reg;
            end
            lst_pkg::CMD_END_SPAN: begin
                if (in_span_active_reg && (in_span_gen_reg == gen_reg) && metric_ok &&
                    !(window_reg && !pend_bit)) begin
                    ok            = 1'b1;
                    op.bump_calls = 1'b1;
                    op.record     = 1'b1;
                    complete      = 1'b1;
                end
            end
            lst_pkg::CMD_RECORD_CALL: begin
                if (metric_ok) begin
                    ok            = 1'b1;
                    op.bump_calls = 1'b1;
                    op.record     = 1'b1;
                    complete      = 1'b1;
                end
            end
            lst_pkg::CMD_RECORD_ONLY: begin
                if (metric_ok) begin
                    ok        = 1'b1;
                    op.record = 1'b1;
                end
            end
            lst_pkg::CMD_START_WINDOW: begin
                if ((in_mask_reg != '0) && ((in_mask_reg & ~VALID_BITS) == '0) &&
                    !enable_reg) begin
                    ok           = 1'b1;
                    gen_next     = lst_pkg::next_gen(gen_reg);
                    pending_next = in_mask_reg;
                    window_next  = 1'b1;
                    enable_next  = 1'b1;
                end
            end
            lst_pkg::CMD_FREEZE: begin
                ok           = 1'b1;
                gen_next     = lst_pkg::next_gen(gen_reg);
                enable_next  = 1'b0;
                pending_next = '0;
                window_next  = 1'b0;
            end
            lst_pkg::CMD_READ: begin
                ok = metric_ok;
            end
            lst_pkg::CMD_SET_BUDGET: begin
                if (metric_ok) begin
                    ok        = 1'b1;
                    budget_we = 1'b1;
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase

        // A metric completed by a span end or a recorded call leaves the window; the last one closes it.
        if (complete && window_reg) begin
            pending_next = pend_cleared;
            if (pend_cleared == '0) begin
                gen_next    = lst_pkg::next_gen(gen_reg);
                window_next = 1'b0;
                enable_next = 1'b0;
            end
        end
    end

    // New entry contents, including a budget write.
    always_comb begin
        entry_next = entry_upd;
        if (budget_we) begin
            entry_next.budget = in_cycles_reg;
        end
    end

    assign entry_we = op.record || budget_we;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            window_reg  <= 1'b0;
            enable_reg  <= 1'b1;
            gen_reg     <= lst_pkg::GEN_RESET;
        end else if (fire) begin
            pending_reg <= pending_next;
            window_reg  <= window_next;
            enable_reg  <= enable_next;
            gen_reg     <= gen_next;
        end
    end

    // Entry write-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_valid_reg <= '0;
        end else if (fire && entry_we) begin
            entry_valid_reg[idx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && entry_we) begin
            entry_reg[idx] <= entry_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_ok_reg     <= ok;
            out_entry_reg  <= metric_ok ? entry_next : '0;
            out_gen_reg    <= gen_next;
            out_enable_reg <= enable_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_ok           = out_ok_reg;
    assign m_calls        = out_entry_reg.calls;
    assign m_samples      = out_entry_reg.samples;
    assign m_minimum      = out_entry_reg.minimum;
    assign m_maximum      = out_entry_reg.maximum;
    assign m_latest       = out_entry_reg.latest;
    assign m_total_cycles = out_entry_reg.total;
    assign m_overruns     = out_entry_reg.overruns;
    assign m_budget       = out_entry_reg.budget;
    assign m_generation   = out_gen_reg;
    assign m_sampling_on  = out_enable_reg;

    // An invalid metric gives a zero entry, so the sample check covers it.
    assign m_meets_budget = (out_entry_reg.samples != '0) && (out_entry_reg.maximum != '0) &&
                            (out_entry_reg.maximum <= out_entry_reg.budget) &&
                            (out_entry_reg.overruns == '0);

endmodule

>>> sim/latency_statistics_table_test.sv
`timescale 1ns / 1ps

module latency_statistics_table_test;

    localparam int SLOTS = lst_pkg::METRIC_SLOTS_DEFAULT;
    localparam logic [31:0] SLOT_BITS = 32'((64'd1 << SLOTS) - 64'd1);

    // One command item as it was accepted by the block.
    typedef struct packed {
        lst_pkg::cmd_t cmd;
        logic [5:0]    metric;
        logic [31:0]   cycles;
        logic [31:0]   window_mask;
        logic [15:0]   span_generation;
        logic          span_active;
    } command_t;

    // One result item: the addressed entry, the generation and the sampling enable.
    typedef struct packed {
        logic        ok;
        logic [31:0] calls;
        logic [31:0] samples;
        logic [31:0] minimum;
        logic [31:0] maximum;
        logic [31:0] latest;
        logic [63:0] total_cycles;
        logic [31:0] overruns;
        logic [31:0] budget;
        logic        meets_budget;
        logic [15:0] generation;
        logic        sampling_on;
    } stats_result_t;

    // Mirror of the statistics table. It predicts the result of every accepted
    // command and holds the results that the block still owes.
    class entry_tracker;
        logic [31:0]   calls_tab [SLOTS];
        logic [31:0]   samples_tab [SLOTS];
        logic [31:0]   min_tab [SLOTS];
        logic [31:0]   max_tab [SLOTS];
        logic [31:0]   latest_tab [SLOTS];
        logic [63:0]   total_tab [SLOTS];
        logic [31:0]   overrun_tab [SLOTS];
        logic [31:0]   budget_tab [SLOTS];
        logic [31:0]   pending_bits;
        bit            window_on;
        bit            sampling;
        logic [15:0]   gen;
        stats_result_t awaited[$];
        int unsigned   errors;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                calls_tab[i] = '0;
                samples_tab[i] = '0;
                min_tab[i] = '0;
                max_tab[i] = '0;
                latest_tab[i] = '0;
                total_tab[i] = '0;
                overrun_tab[i] = '0;
                budget_tab[i] = '1;
            end
            pending_bits = '0;
            window_on = 1'b0;
            sampling = 1'b1;
            gen = 16'd1;
            errors = 0;
        endfunction

        // The generation wraps within 16 bits and skips zero.
        function void advance_generation();
            gen = (gen == 16'hFFFF) ? 16'd1 : gen + 16'd1;
        endfunction

        function void add_sample(int unsigned m, logic [31:0] cyc);
            if (samples_tab[m] != '1) begin
                samples_tab[m]++;
            end
            if (samples_tab[m] == 32'd1 || cyc < min_tab[m]) begin
                min_tab[m] = cyc;
            end
            if (cyc > max_tab[m]) begin
                max_tab[m] = cyc;
            end
            latest_tab[m] = cyc;
            total_tab[m] = total_tab[m] + {32'd0, cyc};
            if (cyc > budget_tab[m] && overrun_tab[m] != '1) begin
                overrun_tab[m]++;
            end
        endfunction

        function void add_call(int unsigned m);
            if (calls_tab[m] != '1) begin
                calls_tab[m]++;
            end
        endfunction

        // A metric that completes a span end or a recorded call while a window is open leaves
        // the pending set; the last one closes the window and stops sampling.
        function void complete_metric(int unsigned m);
            if (!window_on) begin
                return;
            end
            pending_bits[m] = 1'b0;
            if (pending_bits != '0) begin
                return;
            end
            advance_generation();
            window_on = 1'b0;
            sampling = 1'b0;
        endfunction

        function void note_command(command_t c);
            stats_result_t want;
            int unsigned   m;
            bit            hit;
            bit            done;
            m = c.metric;
            hit = (m < SLOTS);
            done = 1'b0;
            case (c.cmd)
                lst_pkg::CMD_BEGIN_SPAN: begin
                    done = sampling;
                end
                lst_pkg::CMD_END_SPAN: begin
                    if (c.span_active && c.span_generation == gen && hit &&
                        !(window_on && !pending_bits[m])) begin
                        add_call(m);
                        add_sample(m, c.cycles);
                        complete_metric(m);
                        done = 1'b1;
                    end
                end
                lst_pkg::CMD_RECORD_CALL: begin
                    if (hit) begin
                        add_call(m);
                        add_sample(m, c.cycles);
                        complete_metric(m);
                        done = 1'b1;
                    end
                end
                lst_pkg::CMD_RECORD_ONLY: begin
                    if (hit) begin
                        add_sample(m, c.cycles);
                        done = 1'b1;
                    end
                end
                lst_pkg::CMD_START_WINDOW: begin
                    if (c.window_mask != '0 && (c.window_mask & ~SLOT_BITS) == '0 &&
                        !sampling) begin
                        advance_generation();
                        pending_bits = c.window_mask;
                        window_on = 1'b1;
                        sampling = 1'b1;
                        done = 1'b1;
                    end
                end
                lst_pkg::CMD_FREEZE: begin
                    advance_generation();
                    sampling = 1'b0;
                    pending_bits = '0;
                    window_on = 1'b0;
                    done = 1'b1;
                end
                lst_pkg::CMD_READ: begin
                    done = hit;
                end
                lst_pkg::CMD_SET_BUDGET: begin
                    if (hit) begin
                        budget_tab[m] = c.cycles;
                        done = 1'b1;
                    end
                end
                default: begin
                    done = 1'b0;
                end
            endcase

            // An invalid metric reads as an all-zero entry.
            want = '0;
            want.ok = done;
            if (hit) begin
                want.calls = calls_tab[m];
                want.samples = samples_tab[m];
                want.minimum = min_tab[m];
                want.maximum = max_tab[m];
                want.latest = latest_tab[m];
                want.total_cycles = total_tab[m];
                want.overruns = overrun_tab[m];
                want.budget = budget_tab[m];
                want.meets_budget = samples_tab[m] != '0 && max_tab[m] != '0 &&
                                    max_tab[m] <= budget_tab[m] && overrun_tab[m] == '0;
            end
            want.generation = gen;
            want.sampling_on = sampling;
            awaited.push_back(want);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(stats_result_t got);
            stats_result_t want;
            if (awaited.size() == 0) begin
                errors++;
                $display("%0t: result item with no command outstanding", $time);
                return;
            end
            want = awaited.pop_front();
            compare_field("ok", 64'(want.ok), 64'(got.ok));
            compare_field("calls", 64'(want.calls), 64'(got.calls));
            compare_field("samples", 64'(want.samples), 64'(got.samples));
            compare_field("minimum", 64'(want.minimum), 64'(got.minimum));
            compare_field("maximum", 64'(want.maximum), 64'(got.maximum));
            compare_field("latest", 64'(want.latest), 64'(got.latest));
            compare_field("total_cycles", want.total_cycles, got.total_cycles);
            compare_field("overruns", 64'(want.overruns), 64'(got.overruns));
            compare_field("budget", 64'(want.budget), 64'(got.budget));
            compare_field("meets_budget", 64'(want.meets_budget), 64'(got.meets_budget));
            compare_field("generation", 64'(want.generation), 64'(got.generation));
            compare_field("sampling_on", 64'(want.sampling_on), 64'(got.sampling_on));
        endfunction
    endclass

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_valid = 1'b0;
    logic          s_ready;
    lst_pkg::cmd_t s_cmd = lst_pkg::CMD_READ;
    logic [5:0]    s_metric = '0;
    logic [31:0]   s_cycles = '0;
    logic [31:0]   s_window_mask = '0;
    logic [15:0]   s_span_generation = '0;
    logic          s_span_active = 1'b0;
    logic          m_valid;
    logic          m_ready = 1'b0;
    logic          m_ok;
    logic [31:0]   m_calls;
    logic [31:0]   m_samples;
    logic [31:0]   m_minimum;
    logic [31:0]   m_maximum;
    logic [31:0]   m_latest;
    logic [63:0]   m_total_cycles;
    logic [31:0]   m_overruns;
    logic [31:0]   m_budget;
    logic          m_meets_budget;
    logic [15:0]   m_generation;
    logic          m_sampling_on;

    entry_tracker  tracker;
    stats_result_t observed;
    bit            idling = 1'b1;
    int unsigned   issued = 0;

    latency_statistics_table #(
        .METRIC_SLOTS(SLOTS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_cmd(s_cmd),
        .s_metric(s_metric),
        .s_cycles(s_cycles),
        .s_window_mask(s_window_mask),
        .s_span_generation(s_span_generation),
        .s_span_active(s_span_active),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_ok(m_ok),
        .m_calls(m_calls),
        .m_samples(m_samples),
        .m_minimum(m_minimum),
        .m_maximum(m_maximum),
        .m_latest(m_latest),
        .m_total_cycles(m_total_cycles),
        .m_overruns(m_overruns),
        .m_budget(m_budget),
        .m_meets_budget(m_meets_budget),
        .m_generation(m_generation),
        .m_sampling_on(m_sampling_on)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10000000;
        $display("CHECK FAILED");
        $finish;
    end

    // The result side stalls in random bursts while idling is enabled.
    initial begin
        forever begin
            if (idling && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // Every result item taken from the block is checked against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            observed.ok = m_ok;
            observed.calls = m_calls;
            observed.samples = m_samples;
            observed.minimum = m_minimum;
            observed.maximum = m_maximum;
            observed.latest = m_latest;
            observed.total_cycles = m_total_cycles;
            observed.overruns = m_overruns;
            observed.budget = m_budget;
            observed.meets_budget = m_meets_budget;
            observed.generation = m_generation;
            observed.sampling_on = m_sampling_on;
            tracker.check_result(observed);
        end
    end

    task automatic hold_off(int unsigned n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Drives one command item, waits for its handshake and records the prediction.
    task automatic issue(lst_pkg::cmd_t cmd, int unsigned metric, logic [31:0] cyc,
                         logic [31:0] mask, logic [15:0] sgen, bit sact);
        command_t c;
        if (idling && $urandom_range(0, 4) == 0) begin
            hold_off($urandom_range(1, 9));
        end
        c.cmd = cmd;
        c.metric = metric[5:0];
        c.cycles = cyc;
        c.window_mask = mask;
        c.span_generation = sgen;
        c.span_active = sact;
        s_valid <= 1'b1;
        s_cmd <= c.cmd;
        s_metric <= c.metric;
        s_cycles <= c.cycles;
        s_window_mask <= c.window_mask;
        s_span_generation <= c.span_generation;
        s_span_active <= c.span_active;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        tracker.note_command(c);
        issued++;
    endtask

    // Most traffic goes to a few hot metrics so that their statistics build up.
    function automatic int unsigned pick_metric();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 14) begin
            return $urandom_range(0, 7);
        end else if (r < 18) begin
            return $urandom_range(0, SLOTS - 1);
        end
        return $urandom_range(SLOTS, 63);
    endfunction

    function automatic logic [31:0] pick_cycles();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return $urandom_range(0, 300);
            4, 5: return $urandom_range(0, 2500);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return $urandom;
            default: return (32'd1 << $urandom_range(0, 7)) | (32'd1 << $urandom_range(0, 7));
        endcase
    endfunction

    task automatic random_single();
        issue(lst_pkg::cmd_t'($urandom_range(0, 7)), pick_metric(), pick_cycles(),
              pick_mask(), $urandom_range(0, 1) ? tracker.gen : 16'($urandom),
              1'($urandom));
    endtask

    // Begin a span, let a few other commands pass, then end it, mostly with the
    // generation and active flag that the begin returned.
    task automatic span_sequence();
        int unsigned m;
        logic [15:0] g;
        bit          act;
        m = pick_metric();
        g = tracker.gen;
        act = tracker.sampling;
        issue(lst_pkg::CMD_BEGIN_SPAN, m, pick_cycles(), pick_mask(), 16'($urandom),
              1'($urandom));
        repeat ($urandom_range(0, 2)) random_single();
        issue(lst_pkg::CMD_END_SPAN, m, pick_cycles(), pick_mask(),
              ($urandom_range(0, 7) == 0) ? 16'($urandom) : g,
              ($urandom_range(0, 7) == 0) ? !act : act);
    endtask

    // Freeze, open a window on a few metrics and complete them one by one, with
    // some unrelated commands mixed in.
    task automatic window_sequence();
        logic [31:0] mask;
        int unsigned start;
        int unsigned idx;
        int          steps;
        if (tracker.sampling || $urandom_range(0, 3) == 0) begin
            issue(lst_pkg::CMD_FREEZE, pick_metric(), pick_cycles(), pick_mask(),
                  16'($urandom), 1'($urandom));
        end
        mask = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'd0;
        repeat ($urandom_range(1, 4)) mask[$urandom_range(0, 7)] = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
            mask[$urandom_range(0, SLOTS - 1)] = 1'b1;
        end
        issue(lst_pkg::CMD_START_WINDOW, pick_metric(), pick_cycles(), mask,
              16'($urandom), 1'($urandom));
        steps = 0;
        while (tracker.window_on && steps < 48) begin
            steps++;
            if ($urandom_range(0, 5) == 0) begin
                random_single();
            end else begin
                start = $urandom_range(0, 31);
                idx = start;
                for (int k = 0; k < 32; k++) begin
                    idx = (start + k) % 32;
                    if (tracker.pending_bits[idx]) break;
                end
                if ($urandom_range(0, 1)) begin
                    issue(lst_pkg::CMD_END_SPAN, idx, pick_cycles(), pick_mask(),
                          tracker.gen, 1'b1);
                end else begin
                    issue(lst_pkg::CMD_RECORD_CALL, idx, pick_cycles(), pick_mask(),
                          16'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    // Short directed pass over the extremes and the gating rules.
    task automatic run_directed();
        issue(lst_pkg::CMD_READ, 0, '0, '0, '0, 1'b0);
        issue(lst_pkg::CMD_READ, SLOTS - 1, '1, '1, '1, 1'b1);
        issue(lst_pkg::CMD_READ, 63, '0, '0, '0, 1'b0);
        issue(lst_pkg::CMD_BEGIN_SPAN, 0, '0, '0, '0, 1'b0);
        issue(lst_pkg::CMD_SET_BUDGET, 0, 32'd100, '0, '0, 1'b0);
        issue(lst_pkg::CMD_SET_BUDGET, 40, 32'd5, '0, '0, 1'b0);
        issue(lst_pkg::CMD_RECORD_CALL, 0, 32'd50, '0, '0, 1'b0);
        // A sample above budget counts as an overrun.
        issue(lst_pkg::CMD_RECORD_ONLY, 0, 32'd200, '0, '0, 1'b0);
        issue(lst_pkg::CMD_RECORD_ONLY, 0, 32'd0, '0, '0, 1'b0);
        // A sample equal to the all-ones budget is no overrun.
        issue(lst_pkg::CMD_RECORD_CALL, SLOTS - 1, '1, '0, '0, 1'b0);
        issue(lst_pkg::CMD_SET_BUDGET, SLOTS - 1, '0, '0, '0, 1'b0);
        // Span ends that are inactive, stale or on an invalid metric are rejected.
        issue(lst_pkg::CMD_END_SPAN, 1, 32'd9, '0, tracker.gen, 1'b0);
        issue(lst_pkg::CMD_END_SPAN, 1, 32'd9, '0, tracker.gen + 16'd1, 1'b1);
        issue(lst_pkg::CMD_END_SPAN, 33, 32'd9, '0, tracker.gen, 1'b1);
        issue(lst_pkg::CMD_END_SPAN, 1, 32'd7, '0, tracker.gen, 1'b1);
        // A window cannot start while sampling is on.
        issue(lst_pkg::CMD_START_WINDOW, 0, '0, 32'h0000_0003, '0, 1'b0);
        issue(lst_pkg::CMD_RECORD_CALL, 63, 32'd11, '0, '0, 1'b0);
        issue(lst_pkg::CMD_FREEZE, 0, '0, '0, '0, 1'b0);
        issue(lst_pkg::CMD_BEGIN_SPAN, 0, '0, '0, '0, 1'b0);
        issue(lst_pkg::CMD_START_WINDOW, 0, '0, '0, '0, 1'b0);
        issue(lst_pkg::CMD_START_WINDOW, 0, '0, 32'h8000_0005, '0, 1'b0);
        // Inside the window only pending metrics may end a span.
        issue(lst_pkg::CMD_END_SPAN, 1, 32'd3, '0, tracker.gen, 1'b1);
        issue(lst_pkg::CMD_END_SPAN, 0, 32'd4, '0, tracker.gen, 1'b1);
        issue(lst_pkg::CMD_RECORD_CALL, 2, 32'd5, '0, '0, 1'b0);
        issue(lst_pkg::CMD_END_SPAN, 31, 32'd6, '0, tracker.gen, 1'b1);
    endtask

    task automatic run_random(int unsigned target);
        int unsigned last;
        last = issued + target;
        while (issued < last) begin
            if ($urandom_range(0, 29) == 0) begin
                idling = !idling;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: random_single();
                3, 4: span_sequence();
                5, 6: window_sequence();
                7: issue(lst_pkg::CMD_SET_BUDGET, $urandom_range(0, 7),
                         $urandom_range(0, 2000), pick_mask(), 16'($urandom),
                         1'($urandom));
                8: issue(lst_pkg::CMD_READ, pick_metric(), pick_cycles(), pick_mask(),
                         16'($urandom), 1'($urandom));
                default: begin
                    repeat (3) begin
                        issue($urandom_range(0, 1) ? lst_pkg::CMD_RECORD_ONLY
                                                   : lst_pkg::CMD_RECORD_CALL,
                              $urandom_range(0, 3), pick_cycles(), pick_mask(),
                              16'($urandom), 1'($urandom));
                    end
                end
            endcase
        end
    endtask

    // Final stretch at full rate on both sides: a short window, then mixed commands.
    task automatic run_tail();
        idling = 1'b0;
        issue(lst_pkg::CMD_FREEZE, 0, '0, '0, '0, 1'b0);
        issue(lst_pkg::CMD_START_WINDOW, 0, '0, 32'h0000_0001, '0, 1'b0);
        issue(lst_pkg::CMD_END_SPAN, 0, 32'd21, '0, tracker.gen, 1'b1);
        issue(lst_pkg::CMD_READ, 0, '0, '0, '0, 1'b0);
        repeat (40) random_single();
    endtask

    initial begin
        tracker = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random(840);
        run_tail();
        s_valid <= 1'b0;
        while (tracker.awaited.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lst_pkg.sv
rtl/core/lst_entry_update.sv
rtl/core/latency_statistics_table.sv
sim/latency_statistics_table_test.sv
